>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, a, c)
`define ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

>>> rtl/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared widths and operation codes.
// ----------------------------------------------------------------------------
package mau_pkg;
  localparam int unsigned VW = 31;
  localparam int unsigned QW = 2 * VW;
  localparam logic [VW-1:0] MOD_RESET = VW'(998244353);
  localparam logic [12:0] SEARCH_MAX = 13'd4097;

  typedef logic [VW-1:0] val_t;

  typedef enum logic [2:0] {
    K_ADD = 3'd0, K_SUB = 3'd1, K_NEG = 3'd2,
    K_MUL = 3'd3, K_DIV = 3'd4, K_ROOT = 3'd5
  } kind_t;

  typedef struct packed {
    logic start;
    logic [QW-1:0] num;
    val_t          den;
  } rem_req_t;
endpackage

>>> rtl/mau_rem.sv
// ----------------------------------------------------------------------------
// Division unit
// Restoring division of a double-width value by a divisor, one bit a cycle,
// giving both the remainder and the low bits of the quotient.
// ----------------------------------------------------------------------------
module mau_rem import mau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  rem_req_t req,
  output logic     done,
  output val_t     rem,
  output val_t     quot
);
  logic [QW-1:0] sh;
  logic [VW:0] r;
  val_t d;
  logic [6:0] cnt;
  logic busy;
  logic [VW:0] trial;
  logic qbit;

  always_comb begin
    trial = {r[VW-1:0], sh[QW-1]};
    qbit = (trial >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      sh <= req.num;
      d <= req.den;
      r <= '0;
      cnt <= 7'(QW);
    end else if (busy) begin
      sh <= {sh[QW-2:0], qbit};
      r <= qbit ? trial - {1'b0, d} : trial;
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign rem = r[VW-1:0];
  assign quot = sh[VW-1:0];
endmodule

>>> rtl/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, negate, multiply, divide and square root modulo a prime.
// ----------------------------------------------------------------------------
// Usage: write modulus through cfg_we and cfg_data while the block is idle.
// Raise start with kind, operand_a and operand_b while busy is low; the beat
// is taken at that edge and busy stays high until the result is shown.
// The result appears on residue and no_answer with done high for one cycle,
// and the next beat can be taken at the edge that ends that cycle.
// Every division and every reduction of a product is done by one shared
// restoring division unit that retires one bit a cycle. Divide runs the
// extended Euclidean algorithm, one division and one product per step.
// Square root runs Euler's test, a base search of one exponentiation per
// candidate, then a Cipolla ladder of up to 31 * 9 products.
// Reset loads the default modulus and idles the sequencer. The receiver
// cannot stall; residue and no_answer hold a result only until the next one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module modular_arithmetic_unit import mau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] kind,
  input  val_t       operand_a,
  input  val_t       operand_b,
  input  logic       cfg_we,
  input  val_t       cfg_data,
  output logic       done,
  output val_t       residue,
  output logic       no_answer
);
  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_RB, S_DISP, S_SIMPLE,
    S_PW_INIT, S_PW_BIT, S_PW_MUL, S_PW_SQ, S_PW_END,
    S_SR_SEARCH, S_SR_W1, S_SR_W2,
    S_CP_INIT, S_CP_BIT, S_CP_M, S_CP_END,
    S_EU_DIV, S_EU_Q, S_EU_T, S_EU_END,
    S_RED, S_FIN
  } st_t;

  st_t st, ret;
  val_t modulus, a, b, w, n;
  val_t pb, pr, pe;
  logic [1:0] pmode;
  logic [12:0] cand;
  val_t r0, r1, b0, b1, t0, t1, t2, ce;
  logic [3:0] ms;
  logic [3:0] cs;
  logic cmul;
  logic [QW-1:0] prod;
  val_t x, y;
  rem_req_t req;
  logic rdone;
  val_t rem;
  val_t quot;
  logic [VW:0] sum;
  val_t res;
  logic flag;

  mau_rem u_rem (
    .clk(clk), .rst(rst), .req(req), .done(rdone), .rem(rem), .quot(quot)
  );

  always_comb begin
    sum = {1'b0, t0} + {1'b0, t1};
    if (sum >= {1'b0, modulus}) sum = sum - {1'b0, modulus};
  end

  assign busy = (st != S_IDLE);

  always_ff @(posedge clk) begin
    req.start <= 1'b0;
    done <= 1'b0;
    prod <= QW'(x) * QW'(y);
    if (rst) begin
      st <= S_IDLE;
      ms <= 4'd0;
      modulus <= MOD_RESET;
    end else begin
      if (cfg_we) modulus <= cfg_data;
      unique case (st)
        S_IDLE: if (start) begin
          a <= operand_a;
          b <= operand_b;
          n <= val_t'(kind);
          if (modulus < val_t'(2)) begin
            res <= '0; flag <= 1'b0; st <= S_FIN;
          end else begin
            req.start <= 1'b1; req.num <= QW'(operand_a); req.den <= modulus;
            st <= S_RA; ret <= S_RA;
          end
        end
        S_RA: if (rdone) begin
          a <= rem; req.start <= 1'b1; req.num <= QW'(b); req.den <= modulus;
          st <= S_RB;
        end
        S_RB: if (rdone) begin
          b <= rem; st <= S_DISP;
        end
        S_DISP: begin
          flag <= 1'b0;
          unique case (n[2:0])
            K_ADD: begin t0 <= a; t1 <= b; st <= S_SIMPLE; end
            K_SUB: begin t0 <= a; t1 <= (b == '0) ? '0 : modulus - b; st <= S_SIMPLE; end
            K_NEG: begin t0 <= '0; t1 <= (a == '0) ? '0 : modulus - a; st <= S_SIMPLE; end
            K_MUL: begin x <= a; y <= b; ms <= 4'd0; ret <= S_FIN; st <= S_RED; end
            K_DIV: begin
              r0 <= modulus; r1 <= b; b0 <= '0; b1 <= val_t'(1); st <= S_EU_DIV;
            end
            K_ROOT: begin
              if (a <= val_t'(1)) begin
                res <= a; st <= S_FIN;
              end else begin
                pb <= a; pe <= (modulus - val_t'(1)) >> 1; pmode <= 2'd1;
                st <= S_PW_INIT;
              end
            end
            default: begin res <= '0; flag <= 1'b1; st <= S_FIN; end
          endcase
        end
        S_SIMPLE: begin res <= sum[VW-1:0]; st <= S_FIN; end
        S_RED: begin
          st <= S_RED;
          if (ms == 4'd0) begin ms <= 4'd1; end
          else if (ms == 4'd1) begin
            req.start <= 1'b1; req.num <= prod; req.den <= modulus; ms <= 4'd2;
          end else if (rdone) begin
            ms <= 4'd0;
            st <= ret;
            if (ret == S_FIN) res <= rem; else t2 <= rem;
          end
        end
        S_EU_DIV: begin
          if (r1 == '0) st <= S_EU_END;
          else begin
            req.start <= 1'b1; req.num <= QW'(r0); req.den <= r1; st <= S_EU_Q;
          end
        end
        S_EU_Q: if (rdone) begin
          r0 <= r1; r1 <= rem; x <= quot; y <= b1; ret <= S_EU_T; st <= S_RED;
        end
        S_EU_T: begin
          b0 <= b1;
          b1 <= (b0 >= t2) ? b0 - t2 : b0 + (modulus - t2);
          st <= S_EU_DIV;
        end
        S_EU_END: begin
          if (r0 != val_t'(1)) begin res <= '0; flag <= 1'b1; st <= S_FIN; end
          else begin x <= a; y <= b0; ret <= S_FIN; st <= S_RED; end
        end
        S_PW_INIT: begin
          pr <= val_t'(1); st <= S_PW_BIT;
        end
        S_PW_BIT: begin
          if (pe == '0) st <= S_PW_END;
          else if (pe[0]) begin x <= pr; y <= pb; ret <= S_PW_MUL; st <= S_RED; end
          else begin x <= pb; y <= pb; ret <= S_PW_SQ; st <= S_RED; end
        end
        S_PW_MUL: begin
          pr <= t2; x <= pb; y <= pb; ret <= S_PW_SQ; st <= S_RED;
        end
        S_PW_SQ: begin
          pb <= t2; pe <= pe >> 1; st <= S_PW_BIT;
        end
        S_PW_END: begin
          unique case (pmode)
            2'd1: begin
              if (pr != val_t'(1)) begin res <= '0; flag <= 1'b1; st <= S_FIN; end
              else begin cand <= 13'd2; st <= S_SR_SEARCH; end
            end
            2'd2: begin
              if (pr == modulus - val_t'(1)) st <= S_CP_INIT;
              else begin cand <= cand + 13'd1; st <= S_SR_SEARCH; end
            end
            default: st <= S_FIN;
          endcase
        end
        S_SR_SEARCH: begin
          if (VW'(cand) >= modulus || cand > SEARCH_MAX) begin
            res <= '0; flag <= 1'b1; st <= S_FIN;
          end else begin
            x <= VW'(cand); y <= VW'(cand); ret <= S_SR_W1; st <= S_RED;
          end
        end
        S_SR_W1: begin
          w <= (t2 >= a) ? t2 - a : t2 + (modulus - a);
          st <= S_SR_W2;
        end
        S_SR_W2: begin
          pb <= w; pe <= (modulus - val_t'(1)) >> 1; pmode <= 2'd2; st <= S_PW_INIT;
        end
        S_CP_INIT: begin
          r0 <= val_t'(1); r1 <= '0; b0 <= VW'(cand); b1 <= val_t'(1);
          ce <= (modulus >> 1) + val_t'(modulus[0]); cmul <= 1'b0; st <= S_CP_BIT;
        end
        S_CP_BIT: begin
          if (ce == '0) st <= S_CP_END;
          else begin cmul <= ce[0]; ms <= 4'd0; cs <= 4'd0; st <= S_CP_M; end
        end
        S_CP_M: begin
          // cs sequences the products of one Cipolla step.
          unique case (cs)
            4'd0: begin
              if (cmul) begin x <= r1; y <= b1; ret <= S_CP_M; cs <= 4'd1; st <= S_RED; end
              else cs <= 4'd6;
            end
            4'd1: begin x <= t2; y <= w; cs <= 4'd2; st <= S_RED; end
            4'd2: begin t0 <= t2; x <= r0; y <= b0; cs <= 4'd3; st <= S_RED; end
            4'd3: begin t1 <= t2; x <= r0; y <= b1; cs <= 4'd4; st <= S_RED; end
            4'd4: begin r0 <= sum[VW-1:0]; t0 <= t2; x <= r1; y <= b0;
              cs <= 4'd5; st <= S_RED; end
            4'd5: begin t1 <= t2; cs <= 4'd13; end
            4'd13: begin r1 <= sum[VW-1:0]; cs <= 4'd6; end
            4'd6: begin x <= b1; y <= b1; ret <= S_CP_M; cs <= 4'd7; st <= S_RED; end
            4'd7: begin x <= t2; y <= w; cs <= 4'd8; st <= S_RED; end
            4'd8: begin t0 <= t2; x <= b0; y <= b0; cs <= 4'd9; st <= S_RED; end
            4'd9: begin t1 <= t2; x <= b0; y <= b1; cs <= 4'd10; st <= S_RED; end
            4'd10: begin b0 <= sum[VW-1:0]; t0 <= t2; t1 <= t2; cs <= 4'd11; end
            4'd11: begin b1 <= sum[VW-1:0]; ce <= ce >> 1; st <= S_CP_BIT; end
            default: cs <= 4'd0;
          endcase
        end
        S_CP_END: begin
          res <= (r0 < modulus - r0) ? r0 : modulus - r0;
          st <= S_FIN;
        end
        S_FIN: begin
          done <= 1'b1;
          residue <= flag ? '0 : res;
          no_answer <= flag;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_done_from_fin, clk, rst, st == S_FIN, done && !busy)
  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, st == S_IDLE)
  `ASSERT_IMPLIES(a_flag_zero, clk, rst, done && no_answer, residue == '0)
endmodule
